// ===== rtl/core/lmtc_pkg.sv =====
package lmtc_pkg;

  // Widths of the transaction fields on the two channels.
  localparam int unsigned ELAPSED_W     = 8;
  localparam int unsigned LINE_NUMBER_W = 8;
  localparam int unsigned MODE_W        = 2;

  // Configuration port geometry: four registers at byte addresses 0, 4, 8 and 12.
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  // Dot within a line at which the line coincidence check is made.
  localparam int unsigned COMPARE_DOT = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_LINE_COMPARE  = 2'd0,
    REG_HBLANK_ENABLE = 2'd1,
    REG_VBLANK_ENABLE = 2'd2,
    REG_OAM_ENABLE    = 2'd3
  } cfg_reg_e;

endpackage

// ===== rtl/core/lmtc_channel_if.sv =====
// Input channel: one transaction carries the machine cycles elapsed since the last one.
interface lmtc_in_if import lmtc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ELAPSED_W-1:0] elapsed_cycles;

  modport source (output valid, output elapsed_cycles, input ready);
  modport sink   (input valid, input elapsed_cycles, output ready);
endinterface

// Output channel: one transaction carries the line, the mode and the request pulses.
interface lmtc_out_if import lmtc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [LINE_NUMBER_W-1:0] line_number;
  logic [MODE_W-1:0]        display_mode;
  logic                     stat_request;
  logic                     vblank_request;
  logic                     render_pulse;
  logic                     frame_done;

  modport source (
    output valid, output line_number, output display_mode, output stat_request,
    output vblank_request, output render_pulse, output frame_done, input ready
  );
  modport sink (
    input valid, input line_number, input display_mode, input stat_request,
    input vblank_request, input render_pulse, input frame_done, output ready
  );
endinterface

// ===== rtl/core/lcd_mode_timing_controller.sv =====
// LCD mode timing controller.
//
// Each transaction on in_i carries the number of machine cycles that have elapsed since the
// previous one. The block adds it to a frame cycle counter that wraps at FRAME_CYCLES, splits
// the counter into a line and a dot, and returns exactly one transaction on out_o with the
// line number, the display mode and the STAT, vblank, render and frame-done requests.
// The user must write the line compare value and the three mode interrupt enables through
// the APB port only while no transaction is in flight; the block does not enforce it. pready
// is always high and reads return the value.
// The datapath is a four-stage pipeline: counter update, reciprocal multiply for the line,
// remainder with a single correction for the dot, then mode decode into the output register.
// A result passes the stage 1, 2 and 3 registers and then the output register, and one
// transaction can be accepted in every cycle while nothing stalls. Each stage has its own
// valid bit and moves on whenever the stage after it is empty or moving, so a stall on
// out_o fills the bubbles first and only then lowers in_i.ready.
//
// Reset clears the frame counter, the previous mode (hblank), the configuration registers
// and all stage valid bits.
module lcd_mode_timing_controller import lmtc_pkg::*; #(
  parameter int unsigned FRAME_CYCLES  = 70224,
  parameter int unsigned LINE_CYCLES   = 456,
  parameter int unsigned VISIBLE_LINES = 144,
  parameter int unsigned OAM_END       = 80,
  parameter int unsigned TRANSFER_END  = 448
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lmtc_in_if.sink               in_i,
  lmtc_out_if.source            out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Counter and its sum before the wrap; the sum needs one more bit than the counter.
  localparam int unsigned CNT_W    = $clog2(FRAME_CYCLES);
  localparam int unsigned SUM_W    = CNT_W + 1;
  localparam int unsigned LINE_MAX = (FRAME_CYCLES - 1) / LINE_CYCLES;
  localparam int unsigned LN_W     = (LINE_MAX > 0) ? $clog2(LINE_MAX + 1) : 1;
  localparam int unsigned DOT_W    = $clog2(LINE_CYCLES);

  // The line is estimated as (count * RECIP) >> RSH. With RECIP rounded down the estimate is
  // never above the true quotient and at most one below it, so one correction step suffices.
  localparam int unsigned RSH    = CNT_W + DOT_W;
  localparam int unsigned M_W    = CNT_W + 1;
  localparam int unsigned PROD_W = CNT_W + M_W;
  localparam logic [M_W-1:0] RECIP = M_W'((64'd1 << RSH) / 64'(LINE_CYCLES));

  // ---------------------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------------------
  logic [7:0] line_compare_q;
  logic       hblank_en_q;
  logic       vblank_en_q;
  logic       oam_en_q;
  logic       cfg_wr;
  cfg_reg_e   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = cfg_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_compare_q <= '0;
      hblank_en_q    <= 1'b0;
      vblank_en_q    <= 1'b0;
      oam_en_q       <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LINE_COMPARE:  line_compare_q <= pwdata[7:0];
        REG_HBLANK_ENABLE: hblank_en_q    <= pwdata[0];
        REG_VBLANK_ENABLE: vblank_en_q    <= pwdata[0];
        REG_OAM_ENABLE:    oam_en_q       <= pwdata[0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_LINE_COMPARE:  prdata = {{(APB_DATA_W-8){1'b0}}, line_compare_q};
      REG_HBLANK_ENABLE: prdata = {{(APB_DATA_W-1){1'b0}}, hblank_en_q};
      REG_VBLANK_ENABLE: prdata = {{(APB_DATA_W-1){1'b0}}, vblank_en_q};
      REG_OAM_ENABLE:    prdata = {{(APB_DATA_W-1){1'b0}}, oam_en_q};
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Pipeline flow control. A stage may load when it is empty or its content moves on.
  // ---------------------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic out_rdy, s3_rdy, s2_rdy, s1_rdy;
  logic in_acc;

  assign out_rdy    = !out_v_q || out_o.ready;
  assign s3_rdy     = !s3_v_q || out_rdy;
  assign s2_rdy     = !s2_v_q || s3_rdy;
  assign s1_rdy     = !s1_v_q || s2_rdy;
  assign in_i.ready = s1_rdy;
  assign in_acc     = in_i.valid && s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_rdy)  s1_v_q  <= in_i.valid;
      if (s2_rdy)  s2_v_q  <= s1_v_q;
      if (s3_rdy)  s3_v_q  <= s2_v_q;
      if (out_rdy) out_v_q <= s3_v_q;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 1: frame counter update with the wrap at the frame length. The elapsed count is
  // always shorter than a frame, so one subtraction brings the sum back into range.
  // ---------------------------------------------------------------------------------------
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0] cnt_sum;
  logic [CNT_W-1:0] s1_cnt_q;

  always_comb begin
    cnt_sum = {1'b0, cnt_q} + SUM_W'(in_i.elapsed_cycles);
    if (cnt_sum >= SUM_W'(FRAME_CYCLES)) begin
      cnt_d = CNT_W'(cnt_sum - SUM_W'(FRAME_CYCLES));
    end else begin
      cnt_d = CNT_W'(cnt_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy) begin
      s1_cnt_q <= cnt_d;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 2: line estimate by multiplying with the reciprocal of the line length.
  // ---------------------------------------------------------------------------------------
  logic [PROD_W-1:0] line_prod;
  logic [LN_W-1:0]   s2_line_q;
  logic [CNT_W-1:0]  s2_cnt_q;

  assign line_prod = PROD_W'(s1_cnt_q) * PROD_W'(RECIP);

  always_ff @(posedge clk_i) begin
    if (s2_rdy) begin
      s2_line_q <= line_prod[RSH +: LN_W];
      s2_cnt_q  <= s1_cnt_q;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 3: remainder gives the dot; a remainder of a full line or more corrects the
  // estimate by one.
  // ---------------------------------------------------------------------------------------
  logic [CNT_W-1:0] line_base;
  logic [CNT_W-1:0] rem;
  logic [LN_W-1:0]  line_fix;
  logic [DOT_W-1:0] dot_fix;
  logic [LN_W-1:0]  s3_line_q;
  logic [DOT_W-1:0] s3_dot_q;

  always_comb begin
    line_base = CNT_W'(32'(s2_line_q) * LINE_CYCLES);
    rem       = s2_cnt_q - line_base;
    if (rem >= CNT_W'(LINE_CYCLES)) begin
      line_fix = s2_line_q + LN_W'(1);
      dot_fix  = DOT_W'(rem - CNT_W'(LINE_CYCLES));
    end else begin
      line_fix = s2_line_q;
      dot_fix  = DOT_W'(rem);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_rdy) begin
      s3_line_q <= line_fix;
      s3_dot_q  <= dot_fix;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 4: mode decode, requests and the output register. The previous mode advances with
  // each result, so the edge pulses follow the order of the transactions.
  // ---------------------------------------------------------------------------------------
  mode_e prev_mode_q, mode_d;
  logic  stat_d, vbl_d, render_d, done_d;

  always_comb begin
    stat_d   = (32'(s3_line_q) == 32'(line_compare_q)) && (32'(s3_dot_q) == COMPARE_DOT);
    vbl_d    = 1'b0;
    render_d = 1'b0;
    if (32'(s3_line_q) < VISIBLE_LINES) begin
      if (32'(s3_dot_q) < OAM_END) begin
        mode_d = MODE_OAM;
        if (oam_en_q) stat_d = 1'b1;
      end else if (32'(s3_dot_q) < TRANSFER_END) begin
        mode_d   = MODE_XFER;
        render_d = (prev_mode_q != MODE_XFER);
      end else begin
        mode_d = MODE_HBLANK;
        if (hblank_en_q) stat_d = 1'b1;
      end
    end else begin
      mode_d = MODE_VBLANK;
      vbl_d  = (prev_mode_q != MODE_VBLANK);
      if (vblank_en_q) stat_d = 1'b1;
    end
    done_d = (prev_mode_q == MODE_VBLANK) && (mode_d != MODE_VBLANK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_mode_q <= MODE_HBLANK;
    end else if (s3_v_q && out_rdy) begin
      prev_mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_v_q && out_rdy) begin
      out_o.line_number    <= LINE_NUMBER_W'(s3_line_q);
      out_o.display_mode   <= mode_d;
      out_o.stat_request   <= stat_d;
      out_o.vblank_request <= vbl_d;
      out_o.render_pulse   <= render_d;
      out_o.frame_done     <= done_d;
    end
  end

  assign out_o.valid = out_v_q;

endmodule

// ===== sim/lcd_mode_timing_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the configuration port, predicts every output transaction and
// compares it with what the controller returns.
module lcd_mode_timing_checker import lmtc_pkg::*; #(
  parameter int unsigned FRAME_CYCLES  = 70224,
  parameter int unsigned LINE_CYCLES   = 456,
  parameter int unsigned VISIBLE_LINES = 144,
  parameter int unsigned OAM_END       = 80,
  parameter int unsigned TRANSFER_END  = 448
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lmtc_in_if                    in_i,
  lmtc_out_if                   out_i,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic                  pready_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [LINE_NUMBER_W-1:0] line;
    mode_e                    mode;
    logic                     stat;
    logic                     vblank;
    logic                     render;
    logic                     done;
  } lcd_status_t;

  logic [7:0]  line_compare_q;
  logic        hblank_en_q;
  logic        vblank_en_q;
  logic        oam_en_q;
  logic [16:0] frame_count_q;
  mode_e       prev_mode_q;

  lcd_status_t status_q[$];
  int unsigned mismatches;

  // Advances the frame counter by one transaction and decodes the status it produces.
  function automatic lcd_status_t advance_timing(input logic [ELAPSED_W-1:0] elapsed);
    int unsigned count;
    int unsigned line;
    int unsigned dot;
    lcd_status_t s;
    count = frame_count_q + elapsed;
    if (count >= FRAME_CYCLES) count -= FRAME_CYCLES;
    line = count / LINE_CYCLES;
    dot  = count % LINE_CYCLES;
    s = '0;
    s.line = line[LINE_NUMBER_W-1:0];
    if (line == line_compare_q && dot == COMPARE_DOT) s.stat = 1'b1;
    if (line < VISIBLE_LINES) begin
      if (dot < OAM_END) begin
        s.mode = MODE_OAM;
        if (oam_en_q) s.stat = 1'b1;
      end else if (dot < TRANSFER_END) begin
        s.mode   = MODE_XFER;
        s.render = (prev_mode_q != MODE_XFER);
      end else begin
        s.mode = MODE_HBLANK;
        if (hblank_en_q) s.stat = 1'b1;
      end
    end else begin
      s.mode   = MODE_VBLANK;
      s.vblank = (prev_mode_q != MODE_VBLANK);
      if (vblank_en_q) s.stat = 1'b1;
    end
    s.done = (prev_mode_q == MODE_VBLANK) && (s.mode != MODE_VBLANK);
    frame_count_q = count[16:0];
    prev_mode_q   = s.mode;
    return s;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    lcd_status_t got;
    lcd_status_t want;
    if (!rst_ni) begin
      line_compare_q = '0;
      hblank_en_q    = 1'b0;
      vblank_en_q    = 1'b0;
      oam_en_q       = 1'b0;
      frame_count_q  = '0;
      prev_mode_q    = MODE_HBLANK;
      mismatches     = 0;
      status_q.delete();
      fail_count_o  <= 0;
      pending_o     <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (cfg_reg_e'(paddr_i[APB_ADDR_W-1:2]))
          REG_LINE_COMPARE:  line_compare_q = pwdata_i[7:0];
          REG_HBLANK_ENABLE: hblank_en_q    = pwdata_i[0];
          REG_VBLANK_ENABLE: vblank_en_q    = pwdata_i[0];
          REG_OAM_ENABLE:    oam_en_q       = pwdata_i[0];
          default: ;
        endcase
      end

      if (out_i.valid && out_i.ready) begin
        got.line   = out_i.line_number;
        got.mode   = mode_e'(out_i.display_mode);
        got.stat   = out_i.stat_request;
        got.vblank = out_i.vblank_request;
        got.render = out_i.render_pulse;
        got.done   = out_i.frame_done;
        if (status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected transaction: line %0d mode %0d stat %b vbl %b rnd %b done %b",
                     $realtime, got.line, got.mode, got.stat, got.vblank, got.render, got.done);
        end else begin
          want = status_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"%0t: mismatch: expected line %0d mode %0d stat %b vbl %b rnd %b done %b,",
                        " actual line %0d mode %0d stat %b vbl %b rnd %b done %b"},
                       $realtime, want.line, want.mode, want.stat, want.vblank, want.render,
                       want.done, got.line, got.mode, got.stat, got.vblank, got.render,
                       got.done);
          end
        end
      end

      if (in_i.valid && in_i.ready) status_q.push_back(advance_timing(in_i.elapsed_cycles));

      fail_count_o <= mismatches;
      pending_o    <= status_q.size();
    end
  end

endmodule

// ===== sim/lcd_mode_timing_controller_tb.sv =====
`timescale 1ns / 1ps

// Top level of the controller's testbench. It only makes stimulus and gives the verdict;
// prediction and comparison are left to the checker, which sits beside the block and hands
// back its count of failures and the number of transactions still awaited.
module lcd_mode_timing_controller_tb;
  import lmtc_pkg::*;

  // Timing of the frame as the block is built here. The stimulus keeps its own running
  // position in the frame so that it can aim steps at the interesting dots of a line.
  localparam int unsigned FRAME_LEN    = 70224;
  localparam int unsigned LINE_LEN     = 456;
  localparam int unsigned OAM_LEN      = 80;
  localparam int unsigned TRANSFER_LEN = 448;

  // The pipeline is four stages deep, and a drain of DRAIN_CYCLES is allowed to pass
  // before the configuration is touched and before the verdict.
  localparam int unsigned DRAIN_CYCLES      = 8;
  localparam int unsigned SEGMENT_ITEMS     = 210;
  localparam int unsigned LONG_STALL_CYCLES = 200;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  lmtc_in_if  in_ch ();
  lmtc_out_if out_ch ();

  int unsigned fail_count;
  int unsigned pending;

  // Idle percentages for each side, and a request counter for the long receiver hold-off.
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned stall_req_cnt;

  // Position within the frame after every transaction sent so far.
  int unsigned frame_pos;

  always #2 clk_i = ~clk_i;

  lcd_mode_timing_controller dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lcd_mode_timing_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Offers one transaction, idling beforehand at random, and returns at the edge at which
  // it is accepted. Valid is only ever assigned once in any one time step.
  task automatic send_elapsed(input logic [ELAPSED_W-1:0] cycles);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.elapsed_cycles <= cycles;
    do @(posedge clk_i); while (!in_ch.ready);
    frame_pos = (frame_pos + cycles) % FRAME_LEN;
  endtask

  // Withdraws the input, waits until every awaited transaction has come back and then lets
  // the pipeline run empty. The checker's count is registered, hence the do-while.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One register write: a setup phase, an access phase, and an idle phase so that writes
  // placed back to back never assign the select twice in one time step.
  task automatic apb_write(input cfg_reg_e idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [APB_DATA_W-1:0] compare,
                               input logic [APB_DATA_W-1:0] hblank_en,
                               input logic [APB_DATA_W-1:0] vblank_en,
                               input logic [APB_DATA_W-1:0] oam_en);
    settle();
    apb_write(REG_LINE_COMPARE, compare);
    apb_write(REG_HBLANK_ENABLE, hblank_en);
    apb_write(REG_VBLANK_ENABLE, vblank_en);
    apb_write(REG_OAM_ENABLE, oam_en);
  endtask

  // Chooses the cycle count of a random transaction. The largest share is spread over the
  // whole range, some are tiny so that single dots are visited, some are large so that whole
  // frames go by; the rest aim at or just before a mode boundary or at the coincidence dot.
  function automatic logic [ELAPSED_W-1:0] pick_elapsed();
    int unsigned roll;
    int unsigned dot;
    int unsigned target;
    int unsigned gap;
    roll = $urandom_range(0, 99);
    if (roll < 35) return ELAPSED_W'($urandom_range(0, 255));
    if (roll < 60) return ELAPSED_W'($urandom_range(0, 8));
    if (roll < 80) return ELAPSED_W'($urandom_range(200, 255));
    dot = frame_pos % LINE_LEN;
    case ($urandom_range(0, 5))
      0:       target = 0;
      1:       target = COMPARE_DOT;
      2:       target = OAM_LEN - 1;
      3:       target = OAM_LEN;
      4:       target = TRANSFER_LEN - 1;
      default: target = TRANSFER_LEN;
    endcase
    gap = (target + LINE_LEN - dot) % LINE_LEN;
    if (gap > 255) return ELAPSED_W'($urandom_range(0, 255));
    return ELAPSED_W'(gap);
  endfunction

  // The receiving side. It is ready at random according to rx_idle_pct, except while it
  // serves a long hold-off: the stimulus asks for one by bumping stall_req_cnt, and the
  // cycles of the hold-off are counted here, so the sender keeps offering transactions and
  // the block has to fill its pipeline and then refuse its input.
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned stall_seen;
    hold_left  = 0;
    stall_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_seen != stall_req_cnt) begin
        stall_seen = stall_req_cnt;
        hold_left  = LONG_STALL_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin : stimulus
    int unsigned seg;
    // Every input of the block is known from time zero onwards.
    rst_ni               <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.elapsed_cycles <= '0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    stall_req_cnt        <= 0;
    rx_idle_pct          <= 66;
    tx_idle_pct           = 33;
    frame_pos             = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed steps under the reset configuration, where the compare line is zero. A step
    // of zero cycles first, then the coincidence dot on line 0, a zero step that stays on
    // it, the last OAM dot, entry to transfer, the last transfer dot, entry to hblank, the
    // wrap into line 1, its coincidence dot (no match now) and the largest step.
    send_elapsed(8'd0);
    send_elapsed(8'd4);
    send_elapsed(8'd0);
    send_elapsed(8'd75);
    send_elapsed(8'd1);
    send_elapsed(8'd0);
    send_elapsed(8'd255);
    send_elapsed(8'd112);
    send_elapsed(8'd1);
    send_elapsed(8'd7);
    send_elapsed(8'd1);
    send_elapsed(8'd4);
    send_elapsed(8'd255);

    // Every mode enable on and a compare line of one: walk through hblank, OAM search and
    // transfer of the next lines with the level requests raised.
    load_settings(32'd1, 32'd1, 32'd1, 32'd1);
    send_elapsed(8'd0);
    send_elapsed(8'd189);
    send_elapsed(8'd8);
    send_elapsed(8'd80);
    send_elapsed(8'd255);
    send_elapsed(8'd255);
    send_elapsed(8'd4);

    // Random segments, each under a setting of its own. The first two idle the sender a
    // third of the time and the receiver two thirds, the next two the other way round,
    // and the last two not at all; the fifth starts with the long hold-off.
    for (seg = 0; seg < 6; seg++) begin
      case (seg)
        0: load_settings(32'd0, 32'd0, 32'd0, 32'd0);
        1: load_settings(32'd255, 32'd1, 32'd1, 32'd1);
        2: load_settings(32'd144, 32'd1, 32'd0, 32'd1);
        3: load_settings(32'd153, 32'd0, 32'd1, 32'd0);
        // Upper bits of the data are random here and must be ignored by the block.
        default: load_settings($urandom(), $urandom(), $urandom(), $urandom());
      endcase
      case (seg)
        0, 1: begin
          tx_idle_pct  = 33;
          rx_idle_pct <= 66;
        end
        2, 3: begin
          tx_idle_pct  = 66;
          rx_idle_pct <= 33;
        end
        default: begin
          tx_idle_pct  = 0;
          rx_idle_pct <= 0;
        end
      endcase
      if (seg == 4) stall_req_cnt <= stall_req_cnt + 1;
      repeat (SEGMENT_ITEMS) send_elapsed(pick_elapsed());
    end

    settle();
    if (fail_count == 0) begin
      $display("lcd_mode_timing_controller test passed");
    end else begin
      $display("lcd_mode_timing_controller test failed");
    end
    $finish;
  end

  // Ends a run that hangs with a failure; a correct run finishes well before this time.
  initial begin : watchdog
    #2000000;
    $display("lcd_mode_timing_controller test failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/lmtc_pkg.sv
rtl/core/lmtc_channel_if.sv
rtl/core/lcd_mode_timing_controller.sv
sim/lcd_mode_timing_checker.sv
sim/lcd_mode_timing_controller_tb.sv
